// File: sv/tps_pkg.sv
`timescale 1ns / 1ps
package tps_pkg;

  localparam int IN_W   = 16;
  localparam int DIFF_W = 17;
  localparam int PROD_W = 34;
  localparam int MAG_W  = 33;
  localparam int SQ_W   = 66;
  localparam int LEN_W  = 68;
  localparam int NORM_W = 18;
  localparam int OFF_W  = 35;
  localparam int Y_W    = 17;
  localparam logic signed [Y_W-1:0] Y_MARGIN = 17'sd5;

  // one classified triangle between front and back
  typedef struct packed {
    logic                     degen;
    logic                     neg_x;
    logic                     neg_y;
    logic                     neg_z;
    logic [LEN_W-1:0]         len2;
    logic [SQ_W-1:0]          sq_x;
    logic [SQ_W-1:0]          sq_y;
    logic [SQ_W-1:0]          sq_z;
    logic signed [IN_W-1:0]   x1;
    logic signed [IN_W-1:0]   y1;
    logic signed [IN_W-1:0]   z1;
    logic signed [Y_W-1:0]    lower;
    logic signed [Y_W-1:0]    upper;
  } tps_item_t;

endpackage

// File: sv/tps_in_if.sv
`timescale 1ns / 1ps
interface tps_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] v1_x;
  logic signed [15:0] v1_y;
  logic signed [15:0] v1_z;
  logic signed [15:0] v2_x;
  logic signed [15:0] v2_y;
  logic signed [15:0] v2_z;
  logic signed [15:0] v3_x;
  logic signed [15:0] v3_y;
  logic signed [15:0] v3_z;
  modport source(output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
                 input ready);
  modport sink(input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
               output ready);
endinterface

// File: sv/tps_out_if.sv
`timescale 1ns / 1ps
interface tps_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [17:0] normal_z;
  logic signed [34:0] plane_offset;
  logic signed [16:0] lower_y;
  logic signed [16:0] upper_y;
  modport source(output valid, valid_res, normal_x, normal_y, normal_z, plane_offset,
                 lower_y, upper_y, input ready);
  modport sink(input valid, valid_res, normal_x, normal_y, normal_z, plane_offset,
               lower_y, upper_y, output ready);
endinterface

// File: sv/tps_front.sv
`timescale 1ns / 1ps
module tps_front
  import tps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tps_in_if.sink    tri_in,
  output logic      push,
  output tps_item_t push_item,
  input  logic      full
);

  logic adv;
  logic v1, v2, v3, v4, v5;

  logic signed [DIFF_W-1:0] ax, ay, az, bx, by, bz;
  logic signed [IN_W-1:0]   s1_x1, s1_y1, s1_z1;
  logic signed [Y_W-1:0]    s1_lower, s1_upper;
  logic signed [IN_W-1:0]   ymin, ymax;

  logic signed [PROD_W-1:0] p_aybz, p_azby, p_azbx, p_axbz, p_axby, p_aybx;
  logic signed [IN_W-1:0]   s2_x1, s2_y1, s2_z1;
  logic signed [Y_W-1:0]    s2_lower, s2_upper;

  logic signed [PROD_W-1:0] cx_next, cy_next, cz_next;
  logic [MAG_W-1:0]         mx, my, mz;
  logic                     s3_nx, s3_ny, s3_nz, s3_degen;
  logic signed [IN_W-1:0]   s3_x1, s3_y1, s3_z1;
  logic signed [Y_W-1:0]    s3_lower, s3_upper;

  tps_item_t s4;
  tps_item_t s5;
  tps_item_t s5_next;

  function automatic logic [MAG_W-1:0] mag(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] a;
    a = v[PROD_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  assign adv          = !v5 || !full;
  assign tri_in.ready = adv;
  assign push         = v5 && !full;
  assign push_item    = s5;

  always_comb begin
    ymin = tri_in.v1_y;
    ymax = tri_in.v1_y;
    if (tri_in.v2_y < ymin) ymin = tri_in.v2_y;
    if (tri_in.v3_y < ymin) ymin = tri_in.v3_y;
    if (tri_in.v2_y > ymax) ymax = tri_in.v2_y;
    if (tri_in.v3_y > ymax) ymax = tri_in.v3_y;
  end

  assign cx_next = p_aybz - p_azby;
  assign cy_next = p_azbx - p_axbz;
  assign cz_next = p_axby - p_aybx;

  always_comb begin
    s5_next      = s4;
    s5_next.len2 = LEN_W'(s4.sq_x) + LEN_W'(s4.sq_y) + LEN_W'(s4.sq_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= tri_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // edge vectors and y bounds
      ax <= DIFF_W'(tri_in.v2_x) - DIFF_W'(tri_in.v1_x);
      ay <= DIFF_W'(tri_in.v2_y) - DIFF_W'(tri_in.v1_y);
      az <= DIFF_W'(tri_in.v2_z) - DIFF_W'(tri_in.v1_z);
      bx <= DIFF_W'(tri_in.v3_x) - DIFF_W'(tri_in.v2_x);
      by <= DIFF_W'(tri_in.v3_y) - DIFF_W'(tri_in.v2_y);
      bz <= DIFF_W'(tri_in.v3_z) - DIFF_W'(tri_in.v2_z);
      s1_x1    <= tri_in.v1_x;
      s1_y1    <= tri_in.v1_y;
      s1_z1    <= tri_in.v1_z;
      s1_lower <= Y_W'(ymin) - Y_MARGIN;
      s1_upper <= Y_W'(ymax) + Y_MARGIN;

      p_aybz <= ay * bz;
      p_azby <= az * by;
      p_azbx <= az * bx;
      p_axbz <= ax * bz;
      p_axby <= ax * by;
      p_aybx <= ay * bx;
      s2_x1    <= s1_x1;
      s2_y1    <= s1_y1;
      s2_z1    <= s1_z1;
      s2_lower <= s1_lower;
      s2_upper <= s1_upper;

      mx       <= mag(cx_next);
      my       <= mag(cy_next);
      mz       <= mag(cz_next);
      s3_nx    <= cx_next[PROD_W-1];
      s3_ny    <= cy_next[PROD_W-1];
      s3_nz    <= cz_next[PROD_W-1];
      s3_degen <= (cx_next == '0) && (cy_next == '0) && (cz_next == '0);
      s3_x1    <= s2_x1;
      s3_y1    <= s2_y1;
      s3_z1    <= s2_z1;
      s3_lower <= s2_lower;
      s3_upper <= s2_upper;

      s4.degen <= s3_degen;
      s4.neg_x <= s3_nx;
      s4.neg_y <= s3_ny;
      s4.neg_z <= s3_nz;
      s4.len2  <= '0;
      s4.sq_x  <= mx * mx;
      s4.sq_y  <= my * my;
      s4.sq_z  <= mz * mz;
      s4.x1    <= s3_x1;
      s4.y1    <= s3_y1;
      s4.z1    <= s3_z1;
      s4.lower <= s3_lower;
      s4.upper <= s3_upper;

      s5 <= s5_next;
    end
  end

endmodule

// File: sv/tps_fifo.sv
`timescale 1ns / 1ps
module tps_fifo
  import tps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tps_item_t push_item,
  input  logic      pop,
  output tps_item_t head,
  output logic      full,
  output logic      empty
);

  localparam int DEPTH = 4;

  tps_item_t  mem [0:DEPTH-1];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign full  = (count == 3'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'(DEPTH))
    else $error("word count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 3'd1)
    else $error("count did not follow push");

endmodule

// File: sv/tps_back.sv
`timescale 1ns / 1ps
module tps_back
  import tps_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  tps_item_t head,
  input  logic      empty,
  output logic      pop,
  tps_out_if.source plane_out
);

  localparam int NS   = FRAC_BITS + 1;
  localparam int W    = 2 * FRAC_BITS + 74;
  localparam int QW   = FRAC_BITS + 1;
  localparam int NW   = FRAC_BITS + 2;
  localparam int PRW  = NW + IN_W;
  localparam int NOW  = (NW > NORM_W) ? NW : NORM_W;
  localparam int OW   = (PRW + 2 > OFF_W) ? PRW + 2 : OFF_W;

  logic adv;

  // search stages: d is the slack against the bound, b tracks len2 * (2q - 1)
  logic                bv   [0:NS];
  tps_item_t           it_r [0:NS];
  logic signed [W-1:0] d_r  [0:NS][0:2];
  logic signed [W-1:0] b_r  [0:NS][0:2];
  logic [QW-1:0]       q_r  [0:NS][0:2];

  logic signed [W-1:0] len_ext;
  logic [SQ_W-1:0]     head_sq [0:2];

  logic                  pv;
  logic                  p_degen;
  logic signed [PRW-1:0] p_prod [0:2];
  logic signed [NOW-1:0] p_norm [0:2];
  logic signed [Y_W-1:0] p_lower, p_upper;

  logic signed [NW-1:0]  n_w [0:2];
  logic signed [IN_W-1:0] vtx [0:2];
  logic                  neg [0:2];
  logic signed [OW-1:0]  off_sum;

  logic                     ov;
  logic                     o_res;
  logic signed [NORM_W-1:0] o_nx, o_ny, o_nz;
  logic signed [OFF_W-1:0]  o_off;
  logic signed [Y_W-1:0]    o_lower, o_upper;

  assign adv = !ov || plane_out.ready;
  assign pop = adv && !empty;

  assign len_ext    = signed'({{(W-LEN_W){1'b0}}, head.len2});
  assign head_sq[0] = head.sq_x;
  assign head_sq[1] = head.sq_y;
  assign head_sq[2] = head.sq_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv[0] <= 1'b0;
    end else if (adv) begin
      bv[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_r[0] <= head;
      for (int j = 0; j < 3; j++) begin
        d_r[0][j] <= (signed'({{(W-SQ_W){1'b0}}, head_sq[j]}) <<< (2 * FRAC_BITS + 2))
                     - len_ext;
        b_r[0][j] <= -len_ext;
        q_r[0][j] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stage
    localparam int K = NS - s;
    logic signed [W-1:0] l_s;
    logic signed [W-1:0] dn [0:2];
    logic                take [0:2];

    assign l_s = signed'({{(W-LEN_W){1'b0}}, it_r[s-1].len2});

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        dn[j]   = d_r[s-1][j] - ((b_r[s-1][j] <<< (K + 2)) + (l_s <<< (2 * K + 2)));
        take[j] = !dn[j][W-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        bv[s] <= 1'b0;
      end else if (adv) begin
        bv[s] <= bv[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        it_r[s] <= it_r[s-1];
        for (int j = 0; j < 3; j++) begin
          d_r[s][j] <= take[j] ? dn[j] : d_r[s-1][j];
          b_r[s][j] <= take[j] ? b_r[s-1][j] + (l_s <<< (K + 1)) : b_r[s-1][j];
          q_r[s][j] <= take[j] ? (q_r[s-1][j] | (QW'(1) << K)) : q_r[s-1][j];
        end
      end
    end
  end

  assign neg[0] = it_r[NS].neg_x;
  assign neg[1] = it_r[NS].neg_y;
  assign neg[2] = it_r[NS].neg_z;
  assign vtx[0] = it_r[NS].x1;
  assign vtx[1] = it_r[NS].y1;
  assign vtx[2] = it_r[NS].z1;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n_w[j] = neg[j] ? -signed'({1'b0, q_r[NS][j]}) : signed'({1'b0, q_r[NS][j]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      pv <= bv[NS];
      ov <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_degen <= it_r[NS].degen;
      p_lower <= it_r[NS].lower;
      p_upper <= it_r[NS].upper;
      for (int j = 0; j < 3; j++) begin
        p_prod[j] <= n_w[j] * vtx[j];
        p_norm[j] <= signed'({{(NOW-NW){n_w[j][NW-1]}}, n_w[j]});
      end
    end
  end

  assign off_sum = -(signed'({{(OW-PRW){p_prod[0][PRW-1]}}, p_prod[0]})
                   + signed'({{(OW-PRW){p_prod[1][PRW-1]}}, p_prod[1]})
                   + signed'({{(OW-PRW){p_prod[2][PRW-1]}}, p_prod[2]}));

  always_ff @(posedge clk) begin
    if (adv) begin
      // a degenerate triangle reports all fields as zero
      o_res   <= !p_degen;
      o_nx    <= p_degen ? '0 : p_norm[0][NORM_W-1:0];
      o_ny    <= p_degen ? '0 : p_norm[1][NORM_W-1:0];
      o_nz    <= p_degen ? '0 : p_norm[2][NORM_W-1:0];
      o_off   <= p_degen ? '0 : off_sum[OFF_W-1:0];
      o_lower <= p_degen ? '0 : p_lower;
      o_upper <= p_degen ? '0 : p_upper;
    end
  end

  assign plane_out.valid        = ov;
  assign plane_out.valid_res    = o_res;
  assign plane_out.normal_x     = o_nx;
  assign plane_out.normal_y     = o_ny;
  assign plane_out.normal_z     = o_nz;
  assign plane_out.plane_offset = o_off;
  assign plane_out.lower_y      = o_lower;
  assign plane_out.upper_y      = o_upper;

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (ov && !o_res) |-> (o_nx == '0 && o_ny == '0 && o_nz == '0 && o_off == '0))
    else $error("degenerate word carries nonzero fields");

endmodule

// File: sv/triangle_plane_setup.sv
`timescale 1ns / 1ps
// Plane setup for one triangle per word: cross product of the edges, unit normal
// rounded to nearest (ties away from zero) with FRAC_BITS fraction bits, plane
// offset -(n.v1) from the rounded normal, and the y span widened by five. A
// degenerate triangle returns valid_res low and all other fields zero. The block
// takes a new triangle every cycle unless a full queue stalls the front; a triangle
// passes through the cross product and length front, the four-word queue, and the
// back end, whose normal search resolves one bit per stage.
module triangle_plane_setup
  import tps_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  tps_in_if.sink    tri_in,
  tps_out_if.source plane_out
);

  logic      push, pop, full, empty;
  tps_item_t push_item, head;

  tps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tri_in    (tri_in),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  tps_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  tps_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .plane_out (plane_out)
  );

endmodule

// File: tb/sv/tps_plane_checker.sv
`timescale 1ns / 1ps
module tps_plane_checker
  import tps_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  tps_in_if    tri_in,
  tps_out_if   plane_out,
  output int   mismatches,
  output int   pending,
  output int   tri_seen,
  output int   degen_seen
);

  typedef struct packed {
    logic                     valid_res;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic signed [OFF_W-1:0]  plane_offset;
    logic signed [Y_W-1:0]    lower_y;
    logic signed [Y_W-1:0]    upper_y;
  } plane_t;

  plane_t plane_q[$];

  // round c * 2^FRAC_BITS / sqrt(len2), ties away from zero, exact search
  function automatic longint round_unit(input longint c, input logic [127:0] len2);
    logic [63:0]  m;
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    logic [63:0]  odd;
    m   = (c < 0) ? -c : c;
    rhs = {64'd0, m} * {64'd0, m};
    rhs = rhs << (2 * FRAC_BITS + 2);
    lo  = 0;
    hi  = 64'd1 << FRAC_BITS;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      lhs = len2 * {64'd0, odd * odd};
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? -longint'(lo) : longint'(lo);
  endfunction

  function automatic plane_t setup_plane(input longint x1, y1, z1, x2, y2, z2,
                                         x3, y3, z3);
    plane_t       p;
    longint       ax, ay, az, bx, by, bz, cx, cy, cz, nx, ny, nz, off, ymin, ymax;
    logic [63:0]  mcx, mcy, mcz;
    logic [127:0] len2;
    ax = x2 - x1; ay = y2 - y1; az = z2 - z1;
    bx = x3 - x2; by = y3 - y2; bz = z3 - z2;
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    p = '0;
    if (cx == 0 && cy == 0 && cz == 0) return p;
    // squares reach 66 bits, so they are formed at full width
    mcx = (cx < 0) ? -cx : cx;
    mcy = (cy < 0) ? -cy : cy;
    mcz = (cz < 0) ? -cz : cz;
    len2 = {64'd0, mcx} * {64'd0, mcx} + {64'd0, mcy} * {64'd0, mcy}
           + {64'd0, mcz} * {64'd0, mcz};
    nx = round_unit(cx, len2);
    ny = round_unit(cy, len2);
    nz = round_unit(cz, len2);
    off = -(nx * x1 + ny * y1 + nz * z1);
    ymin = y1; ymax = y1;
    if (y2 < ymin) ymin = y2;
    if (y3 < ymin) ymin = y3;
    if (y2 > ymax) ymax = y2;
    if (y3 > ymax) ymax = y3;
    p.valid_res    = 1'b1;
    p.normal_x     = nx[NORM_W-1:0];
    p.normal_y     = ny[NORM_W-1:0];
    p.normal_z     = nz[NORM_W-1:0];
    p.plane_offset = off[OFF_W-1:0];
    p.lower_y      = Y_W'(ymin - 5);
    p.upper_y      = Y_W'(ymax + 5);
    return p;
  endfunction

  assign pending = plane_q.size();

  always @(posedge clk) begin
    plane_t exp_p;
    plane_t got;
    if (rst) begin
      mismatches = 0;
      tri_seen   = 0;
      degen_seen = 0;
    end
    if (!rst && tri_in.valid && tri_in.ready) begin
      exp_p = setup_plane(tri_in.v1_x, tri_in.v1_y, tri_in.v1_z,
                          tri_in.v2_x, tri_in.v2_y, tri_in.v2_z,
                          tri_in.v3_x, tri_in.v3_y, tri_in.v3_z);
      plane_q.push_back(exp_p);
      tri_seen++;
      if (!exp_p.valid_res) degen_seen++;
    end
    if (!rst && plane_out.valid && plane_out.ready) begin
      got.valid_res    = plane_out.valid_res;
      got.normal_x     = plane_out.normal_x;
      got.normal_y     = plane_out.normal_y;
      got.normal_z     = plane_out.normal_z;
      got.plane_offset = plane_out.plane_offset;
      got.lower_y      = plane_out.lower_y;
      got.upper_y      = plane_out.upper_y;
      if (plane_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        exp_p = plane_q.pop_front();
        if (got !== exp_p) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_p, got);
        end
      end
    end
  end

endmodule

// File: tb/sv/triangle_plane_setup_tb.sv
`timescale 1ns / 1ps
module triangle_plane_setup_tb;
  import tps_pkg::*;

  localparam int N_RANDOM = 1630;
  localparam int N_QUIET  = 200;
  localparam int LIMIT    = 400000;

  logic clk;
  logic rst;
  logic quiet;
  int   mismatches, pending, tri_seen, degen_seen;
  int   cycles;

  tps_in_if  tri_in();
  tps_out_if plane_out();

  triangle_plane_setup #(.FRAC_BITS(16)) i_dut (
    .clk(clk), .rst(rst), .tri_in(tri_in), .plane_out(plane_out)
  );

  tps_plane_checker #(.FRAC_BITS(16)) i_checker (
    .clk(clk), .rst(rst), .tri_in(tri_in), .plane_out(plane_out),
    .mismatches(mismatches), .pending(pending), .tri_seen(tri_seen),
    .degen_seen(degen_seen)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycles <= (rst) ? 0 : cycles + 1;
    if (!rst && cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic put_tri(input logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    int gap;
    tri_in.valid <= 1'b1;
    tri_in.v1_x <= ax; tri_in.v1_y <= ay; tri_in.v1_z <= az;
    tri_in.v2_x <= bx; tri_in.v2_y <= by; tri_in.v2_z <= bz;
    tri_in.v3_x <= cx; tri_in.v3_y <= cy; tri_in.v3_z <= cz;
    @(posedge clk);
    while (!tri_in.ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      tri_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] rnd_small(input int r);
    return 16'($urandom_range(0, 2 * r) - r);
  endfunction

  // receiver: random stall bursts, one long hold-off early on
  initial begin
    int stall;
    plane_out.ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    repeat (300) begin
      plane_out.ready <= 1'b1;
      @(posedge clk);
    end
    plane_out.ready <= 1'b0;
    repeat (400) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 17);
        plane_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      plane_out.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    logic signed [15:0] p[9];
    logic signed [15:0] dx, dy, dz;
    int kind, k;
    rst = 1'b1;
    quiet = 1'b0;
    tri_in.valid = 1'b0;
    {tri_in.v1_x, tri_in.v1_y, tri_in.v1_z} = '0;
    {tri_in.v2_x, tri_in.v2_y, tri_in.v2_z} = '0;
    {tri_in.v3_x, tri_in.v3_y, tri_in.v3_z} = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: degenerate, extremes, axis planes, collinear
    put_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    put_tri(100, 200, 300, 100, 200, 300, 100, 200, 300);
    put_tri(0, 0, 0, 1, 1, 1, 2, 2, 2);
    put_tri(-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768);
    put_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    put_tri(0, 0, 0, 0, 1, 0, 1, 0, 0);
    put_tri(0, 0, 0, 0, 0, 1, 1, 0, 0);
    put_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
    put_tri(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0);
    put_tri(32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768);
    put_tri(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767);
    put_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767);
    put_tri(32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767, -32768);
    put_tri(1, 2, 3, 4, 5, 6, 7, 8, 10);
    put_tri(-1, -1, -1, 0, 0, 0, 1, 0, -1);
    put_tri(10, -20, 30, 10, -20, 30, -5, 7, 9);
    put_tri(0, 32767, 0, 0, -32768, 0, 1, 0, 0);
    put_tri(5, 5, 5, 6, 5, 5, 5, 6, 6);
    put_tri(-32768, 0, 32767, 32767, 0, -32768, 0, 1, 0);
    put_tri(3, 4, 0, 0, 0, 0, 4, -3, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        foreach (p[i]) p[i] = rnd16();
      end else if (kind < 7) begin
        p[0] = rnd_small(30000); p[1] = rnd_small(30000); p[2] = rnd_small(30000);
        for (int i = 3; i < 9; i++) p[i] = p[i % 3] + rnd_small(8);
      end else if (kind < 9) begin
        // collinear or repeated vertices
        p[0] = rnd_small(8000); p[1] = rnd_small(8000); p[2] = rnd_small(8000);
        dx = rnd_small(100); dy = rnd_small(100); dz = rnd_small(100);
        k = $urandom_range(0, 40) - 20;
        p[3] = p[0] + dx; p[4] = p[1] + dy; p[5] = p[2] + dz;
        p[6] = p[3] + 16'(k * dx);
        p[7] = p[4] + 16'(k * dy);
        p[8] = p[5] + 16'(k * dz);
        if ($urandom_range(0, 3) == 0) begin
          p[6] = p[0]; p[7] = p[1]; p[8] = p[2];
        end
      end else begin
        foreach (p[i]) p[i] = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      end
      put_tri(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
    end
    tri_in.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("%0d triangles checked, %0d degenerate, random gaps and stalls",
             tri_seen, degen_seen);
    $display("included a long output hold-off that backed up the input");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching words", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: triangle_plane_setup.f
sv/tps_pkg.sv
sv/tps_in_if.sv
sv/tps_out_if.sv
sv/tps_front.sv
sv/tps_fifo.sv
sv/tps_back.sv
sv/triangle_plane_setup.sv
tb/sv/tps_plane_checker.sv
tb/sv/triangle_plane_setup_tb.sv
